// ===== hw/rtl/btp_pkg.sv =====
`default_nettype none
package btp_pkg;

	// Input field widths.
	localparam int POS_W = 24;
	localparam int VEL_W = 20;
	localparam int GRV_W = 17;

	// Position difference, magnitude and products.
	localparam int DIF_W = POS_W + 1;
	localparam int VSQ_W = 2 * VEL_W;
	localparam int GD_W = GRV_W + DIF_W;
	localparam int DISC_W = GD_W + 1;
	localparam int DISCU_W = DISC_W - 1;

	// Square root: floor(sqrt(disc * 2^32)).
	localparam int FRAC_W = 16;
	localparam int ROOT_W = 37;
	localparam int REM_W = ROOT_W + 3;
	localparam int SQ_ITERS = ROOT_W;
	localparam int SQ_PER = 2;
	localparam int SQ_STAGES = (SQ_ITERS + SQ_PER - 1) / SQ_PER;

	// Root numerators and divider operands.
	localparam int VQ_W = VEL_W + FRAC_W;
	localparam int QN_W = ROOT_W + 2;
	localparam int NUM_W = DIF_W + FRAC_W + 1;
	localparam int UN_W = NUM_W - 1;
	localparam int NN_W = NUM_W;
	localparam int UD_W = VEL_W;
	localparam int DD_W = UD_W + 1;
	localparam int TT_W = 25;
	localparam int DV_STEPS = TT_W;
	localparam int DV_PER = 2;
	localparam int DV_STAGES = (DV_STEPS + DV_PER - 1) / DV_PER;
	localparam int HI_W = NN_W - TT_W;

	localparam logic signed [TT_W-1:0] TT_MAX = 25'sh0FF_FFFF;
	localparam logic signed [TT_W-1:0] TT_MIN = 25'sh100_0000;
	localparam logic signed [TT_W-1:0] TT_NO_SOL = -25'sd65536;

	localparam logic [1:0] ST_ZERO = 2'd0;
	localparam logic [1:0] ST_LIN = 2'd1;
	localparam logic [1:0] ST_QUAD = 2'd2;
	localparam logic [1:0] ST_NONE = 2'd3;

	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [1:0] AX_Z = 2'd2;
	localparam logic [1:0] AX_NONE = 2'd3;

	typedef struct packed {
		logic signed [DIF_W-1:0] dx;
		logic signed [DIF_W-1:0] dy;
		logic signed [DIF_W-1:0] dz;
		logic signed [VEL_W-1:0] vx;
		logic signed [VEL_W-1:0] vy;
		logic signed [VEL_W-1:0] vz;
		logic signed [GRV_W-1:0] g;
		logic [1:0] px;
		logic [1:0] py;
		logic [1:0] pz;
		logic zero;
		logic disc_ok;
	} sq_meta_t;

	typedef struct packed {
		logic neg;
		logic ovf;
		logic [1:0] status;
		logic [1:0] axis;
	} dv_meta_t;

endpackage
`default_nettype wire

// ===== hw/rtl/btp_front.sv =====
`default_nettype none
module btp_front import btp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic in_valid,
	input wire logic signed [POS_W-1:0] start_x,
	input wire logic signed [POS_W-1:0] start_y,
	input wire logic signed [POS_W-1:0] start_z,
	input wire logic signed [VEL_W-1:0] vel_x,
	input wire logic signed [VEL_W-1:0] vel_y,
	input wire logic signed [VEL_W-1:0] vel_z,
	input wire logic signed [GRV_W-1:0] grav,
	input wire logic signed [POS_W-1:0] dest_x,
	input wire logic signed [POS_W-1:0] dest_y,
	input wire logic signed [POS_W-1:0] dest_z,
	output logic out_valid,
	output sq_meta_t out_meta,
	output logic [DISCU_W-1:0] out_disc
);

	logic valid_s1, valid_s2, valid_s3;
	logic signed [DIF_W-1:0] dx_s1, dy_s1, dz_s1;
	logic signed [VEL_W-1:0] vx_s1, vy_s1, vz_s1;
	logic signed [GRV_W-1:0] g_s1;
	sq_meta_t meta_s2, meta_s3;
	logic signed [VSQ_W-1:0] vsq_s2;
	logic signed [GD_W-1:0] gd_s2;
	logic [DISCU_W-1:0] disc_s3;

	logic [DIF_W-1:0] mx, my, mz;
	logic signed [VSQ_W-1:0] vsq;
	logic signed [GD_W-1:0] gd;
	logic signed [DISC_W-1:0] disc;
	sq_meta_t meta_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Magnitudes of the differences; the most negative difference still fits unsigned.
	always_comb begin
		mx = dx_s1[DIF_W-1] ? DIF_W'(-dx_s1) : DIF_W'(dx_s1);
		my = dy_s1[DIF_W-1] ? DIF_W'(-dy_s1) : DIF_W'(dy_s1);
		mz = dz_s1[DIF_W-1] ? DIF_W'(-dz_s1) : DIF_W'(dz_s1);
		vsq = vz_s1 * vz_s1;
		gd = g_s1 * dz_s1;
		disc = DISC_W'(vsq_s2) - $signed({gd_s2, 1'b0});
		meta_nx = meta_s2;
		meta_nx.disc_ok = !disc[DISC_W-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= DIF_W'(dest_x) - DIF_W'(start_x);
			dy_s1 <= DIF_W'(dest_y) - DIF_W'(start_y);
			dz_s1 <= DIF_W'(dest_z) - DIF_W'(start_z);
			vx_s1 <= vel_x;
			vy_s1 <= vel_y;
			vz_s1 <= vel_z;
			g_s1 <= grav;

			meta_s2.dx <= dx_s1;
			meta_s2.dy <= dy_s1;
			meta_s2.dz <= dz_s1;
			meta_s2.vx <= vx_s1;
			meta_s2.vy <= vy_s1;
			meta_s2.vz <= vz_s1;
			meta_s2.g <= g_s1;
			// Rank of each axis; on equal magnitudes the lower axis comes first.
			meta_s2.px <= 2'(my > mx) + 2'(mz > mx);
			meta_s2.py <= 2'(mx >= my) + 2'(mz > my);
			meta_s2.pz <= 2'(mx >= mz) + 2'(my >= mz);
			meta_s2.zero <= (mx == '0) && (my == '0) && (mz == '0);
			meta_s2.disc_ok <= 1'b0;
			vsq_s2 <= vsq;
			gd_s2 <= gd;

			meta_s3 <= meta_nx;
			disc_s3 <= disc[DISCU_W-1:0];
		end
	end

	assign out_valid = valid_s3;
	assign out_meta = meta_s3;
	assign out_disc = disc_s3;

endmodule
`default_nettype wire

// ===== hw/rtl/btp_sqrt.sv =====
`default_nettype none
module btp_sqrt import btp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic in_valid,
	input wire sq_meta_t in_meta,
	input wire logic [DISCU_W-1:0] in_disc,
	output logic out_valid,
	output sq_meta_t out_meta,
	output logic [ROOT_W-1:0] out_root
);

	// Index 0 is the stage input; index s+1 is the register after stage s.
	logic valid_s [SQ_STAGES+1];
	sq_meta_t meta_s [SQ_STAGES+1];
	logic [DISCU_W-1:0] disc_s [SQ_STAGES+1];
	logic [ROOT_W-1:0] root_s [SQ_STAGES+1];
	logic [REM_W-1:0] rem_s [SQ_STAGES+1];

	assign valid_s[0] = in_valid;
	assign meta_s[0] = in_meta;
	assign disc_s[0] = in_disc;
	assign root_s[0] = '0;
	assign rem_s[0] = '0;

	for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
		logic [ROOT_W-1:0] root_nx;
		logic [REM_W-1:0] rem_nx;

		// Two restoring steps (one in the last stage), one result bit each; pairs below the binary point are zero.
		always_comb begin
			logic [REM_W-1:0] r;
			logic [REM_W-1:0] tr;
			logic [ROOT_W-1:0] q;
			logic [1:0] pr;
			int idx;
			int k;
			r = rem_s[s];
			q = root_s[s];
			for (int j = 0; j < SQ_PER; j++) begin
				idx = s * SQ_PER + j;
				k = SQ_ITERS - 1 - idx;
				pr = 2'b00;
				if (idx < SQ_ITERS) begin
					if (k >= FRAC_W)
						pr = 2'(disc_s[s] >> (2 * k - 2 * FRAC_W));
					r = {r[REM_W-3:0], pr};
					tr = {1'b0, q, 2'b01};
					if (r >= tr) begin
						r = r - tr;
						q = {q[ROOT_W-2:0], 1'b1};
					end else begin
						q = {q[ROOT_W-2:0], 1'b0};
					end
				end
			end
			root_nx = q;
			rem_nx = r;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				valid_s[s+1] <= 1'b0;
			else if (en)
				valid_s[s+1] <= valid_s[s];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				meta_s[s+1] <= meta_s[s];
				disc_s[s+1] <= disc_s[s];
				root_s[s+1] <= root_nx;
				rem_s[s+1] <= rem_nx;
			end
		end
	end

	assign out_valid = valid_s[SQ_STAGES];
	assign out_meta = meta_s[SQ_STAGES];
	assign out_root = root_s[SQ_STAGES];

endmodule
`default_nettype wire

// ===== hw/rtl/btp_select.sv =====
`default_nettype none
module btp_select import btp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic in_valid,
	input wire sq_meta_t in_meta,
	input wire logic [ROOT_W-1:0] in_root,
	output logic out_valid,
	output logic signed [NUM_W-1:0] out_num,
	output logic signed [VEL_W-1:0] out_den,
	output logic [1:0] out_status,
	output logic [1:0] out_axis
);

	logic valid_s1;
	logic signed [NUM_W-1:0] num_s1;
	logic signed [VEL_W-1:0] den_s1;
	logic [1:0] status_s1, axis_s1;

	logic signed [QN_W-1:0] vq, n1, n2, lo, hi, nq;
	logic gpos, gneg, quad, ok_lo, ok_hi, ok_x, ok_y, ok_z, sel_x, sel_y, sel_z;
	logic signed [NUM_W-1:0] num;
	logic signed [VEL_W-1:0] den;
	logic [1:0] status, axis;

	always_comb begin
		vq = QN_W'($signed({in_meta.vz, {FRAC_W{1'b0}}}));
		n1 = vq - $signed({2'b00, in_root});
		n2 = vq + $signed({2'b00, in_root});
		quad = in_meta.g != '0;
		gneg = in_meta.g[GRV_W-1];
		gpos = quad && !gneg;
		lo = gpos ? n1 : n2;
		hi = gpos ? n2 : n1;
		// A root is usable unless numerator and gravity have strictly opposite signs.
		ok_lo = !((lo[QN_W-1] && gpos) || (!lo[QN_W-1] && lo != '0 && gneg));
		ok_hi = !((hi[QN_W-1] && gpos) || (!hi[QN_W-1] && hi != '0 && gneg));
		nq = ok_lo ? lo : hi;

		ok_x = in_meta.vx != '0;
		ok_y = in_meta.vy != '0;
		ok_z = quad ? (in_meta.disc_ok && (ok_lo || ok_hi)) : (in_meta.vz != '0);

		// The usable axis of lowest rank wins.
		sel_x = ok_x && !(ok_y && in_meta.py < in_meta.px) && !(ok_z && in_meta.pz < in_meta.px);
		sel_y = ok_y && !(ok_x && in_meta.px < in_meta.py) && !(ok_z && in_meta.pz < in_meta.py);
		sel_z = ok_z && !(ok_x && in_meta.px < in_meta.pz) && !(ok_y && in_meta.py < in_meta.pz);

		num = NUM_W'($signed({in_meta.dz, {FRAC_W{1'b0}}}));
		den = in_meta.vz;
		status = ST_NONE;
		axis = AX_NONE;
		if (in_meta.zero) begin
			status = ST_ZERO;
		end else if (sel_x) begin
			num = NUM_W'($signed({in_meta.dx, {FRAC_W{1'b0}}}));
			den = in_meta.vx;
			status = ST_LIN;
			axis = AX_X;
		end else if (sel_y) begin
			num = NUM_W'($signed({in_meta.dy, {FRAC_W{1'b0}}}));
			den = in_meta.vy;
			status = ST_LIN;
			axis = AX_Y;
		end else if (sel_z) begin
			axis = AX_Z;
			if (quad) begin
				num = NUM_W'(nq);
				den = VEL_W'(in_meta.g);
				status = ST_QUAD;
			end else begin
				status = ST_LIN;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= num;
			den_s1 <= den;
			status_s1 <= status;
			axis_s1 <= axis;
		end
	end

	assign out_valid = valid_s1;
	assign out_num = num_s1;
	assign out_den = den_s1;
	assign out_status = status_s1;
	assign out_axis = axis_s1;

endmodule
`default_nettype wire

// ===== hw/rtl/btp_div.sv =====
`default_nettype none
module btp_div import btp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic in_valid,
	input wire logic signed [NUM_W-1:0] in_num,
	input wire logic signed [VEL_W-1:0] in_den,
	input wire logic [1:0] in_status,
	input wire logic [1:0] in_axis,
	output logic out_valid,
	output dv_meta_t out_meta,
	output logic [TT_W-1:0] out_quot
);

	logic [UN_W-1:0] un;
	logic [UD_W-1:0] ud;
	logic [NN_W-1:0] nn;
	logic [DD_W-1:0] dd;

	// Index 0 is the operand register; index s+1 follows step stage s.
	logic valid_s [DV_STAGES+1];
	dv_meta_t meta_s [DV_STAGES+1];
	logic [DD_W-1:0] dd_s [DV_STAGES+1];
	logic [TT_W-1:0] nlo_s [DV_STAGES+1];
	logic [DD_W-1:0] rem_s [DV_STAGES+1];
	logic [TT_W-1:0] quot_s [DV_STAGES+1];

	// Rounded quotient = floor((2|n| + |d|) / (2|d|)).
	always_comb begin
		un = in_num[NUM_W-1] ? UN_W'(-in_num) : UN_W'(in_num);
		ud = in_den[VEL_W-1] ? UD_W'(-in_den) : UD_W'(in_den);
		nn = {un, 1'b0} + NN_W'(ud);
		dd = {ud, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s[0] <= 1'b0;
		else if (en)
			valid_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s[0].neg <= in_num[NUM_W-1] != in_den[VEL_W-1];
			meta_s[0].ovf <= (NN_W + DD_W)'(nn) >= ((NN_W + DD_W)'(dd) << TT_W);
			meta_s[0].status <= in_status;
			meta_s[0].axis <= in_axis;
			dd_s[0] <= dd;
			nlo_s[0] <= nn[TT_W-1:0];
			rem_s[0] <= DD_W'(nn[NN_W-1:TT_W]);
			quot_s[0] <= '0;
		end
	end

	for (genvar s = 0; s < DV_STAGES; s++) begin : g_stage
		logic [DD_W-1:0] rem_nx;
		logic [TT_W-1:0] quot_nx;

		// Restoring long division, one quotient bit per step.
		always_comb begin
			logic [DD_W:0] r;
			logic [DD_W-1:0] rm;
			logic [TT_W-1:0] q;
			int idx;
			rm = rem_s[s];
			q = quot_s[s];
			for (int j = 0; j < DV_PER; j++) begin
				idx = s * DV_PER + j;
				if (idx < DV_STEPS) begin
					r = {rm, nlo_s[s][TT_W-1-idx]};
					if (r >= {1'b0, dd_s[s]}) begin
						rm = DD_W'(r - {1'b0, dd_s[s]});
						q = {q[TT_W-2:0], 1'b1};
					end else begin
						rm = DD_W'(r);
						q = {q[TT_W-2:0], 1'b0};
					end
				end
			end
			rem_nx = rm;
			quot_nx = q;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				valid_s[s+1] <= 1'b0;
			else if (en)
				valid_s[s+1] <= valid_s[s];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				meta_s[s+1] <= meta_s[s];
				dd_s[s+1] <= dd_s[s];
				nlo_s[s+1] <= nlo_s[s];
				rem_s[s+1] <= rem_nx;
				quot_s[s+1] <= quot_nx;
			end
		end
	end

	assign out_valid = valid_s[DV_STAGES];
	assign out_meta = meta_s[DV_STAGES];
	assign out_quot = quot_s[DV_STAGES];

endmodule
`default_nettype wire

// ===== hw/rtl/ballistic_time_to_point_top.sv =====
// Throughput: one request per cycle while the output register is free or being drained;
// the 19-stage square root and the 14-stage divider (an operand register and 13 step
// stages) each take a new operand every cycle while the pipeline is enabled.
// Reset: arst_n clears every valid bit at once; data registers are not reset.
`default_nettype none
module ballistic_time_to_point_top import btp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// From bit 0: start_x[23:0], start_y[23:0], start_z[23:0], vel_x[19:0], vel_y[19:0],
	// vel_z[19:0], grav[16:0], dest_x[23:0], dest_y[23:0], dest_z[23:0], 3 zero bits.
	input wire logic [223:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// From bit 0: flight_time[24:0], axis_used[1:0], 5 zero bits.
	output logic [31:0] m_axis_tdata,
	// solve_status[1:0].
	output logic [1:0] m_axis_tuser
);

	// The whole pipeline moves as one whenever the output register is free or being
	// drained. Bubbles inside the pipeline stay in place while the output is stalled, and
	// nothing is dropped or repeated because every stage holds when the enable is low.
	logic en;

	logic fr_valid;
	sq_meta_t fr_meta;
	logic [DISCU_W-1:0] fr_disc;

	logic sq_valid;
	sq_meta_t sq_meta;
	logic [ROOT_W-1:0] sq_root;

	logic sl_valid;
	logic signed [NUM_W-1:0] sl_num;
	logic signed [VEL_W-1:0] sl_den;
	logic [1:0] sl_status, sl_axis;

	logic dv_valid;
	dv_meta_t dv_meta;
	logic [TT_W-1:0] dv_quot;

	logic signed [TT_W-1:0] time_nx;

	logic out_valid_q;
	logic signed [TT_W-1:0] time_q;
	logic [1:0] status_q, axis_q;

	assign en = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;

	// Stages 1-3: differences, axis ranking, and the discriminant vz^2 - 2*g*dz.
	btp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(s_axis_tvalid),
		.start_x(s_axis_tdata[23:0]),
		.start_y(s_axis_tdata[47:24]),
		.start_z(s_axis_tdata[71:48]),
		.vel_x(s_axis_tdata[91:72]),
		.vel_y(s_axis_tdata[111:92]),
		.vel_z(s_axis_tdata[131:112]),
		.grav(s_axis_tdata[148:132]),
		.dest_x(s_axis_tdata[172:149]),
		.dest_y(s_axis_tdata[196:173]),
		.dest_z(s_axis_tdata[220:197]),
		.out_valid(fr_valid),
		.out_meta(fr_meta),
		.out_disc(fr_disc)
	);

	// Square root of the discriminant with 16 fraction bits, two bits per stage (one in the last stage).
	btp_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(fr_valid),
		.in_meta(fr_meta),
		.in_disc(fr_disc),
		.out_valid(sq_valid),
		.out_meta(sq_meta),
		.out_root(sq_root)
	);

	// Picks the first usable axis in rank order and its numerator and denominator.
	btp_select u_select (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(sq_valid),
		.in_meta(sq_meta),
		.in_root(sq_root),
		.out_valid(sl_valid),
		.out_num(sl_num),
		.out_den(sl_den),
		.out_status(sl_status),
		.out_axis(sl_axis)
	);

	// Rounded magnitude of the quotient, with an overflow flag for saturation.
	btp_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(sl_valid),
		.in_num(sl_num),
		.in_den(sl_den),
		.in_status(sl_status),
		.in_axis(sl_axis),
		.out_valid(dv_valid),
		.out_meta(dv_meta),
		.out_quot(dv_quot)
	);

	// Sign, saturation, and the fixed answers for the zero vector and for no solution.
	always_comb begin
		if (dv_meta.neg) begin
			if (dv_meta.ovf || dv_quot > TT_W'(unsigned'(TT_MAX)) + 1'b1)
				time_nx = TT_MIN;
			else
				time_nx = TT_W'(-$signed(dv_quot));
		end else begin
			if (dv_meta.ovf || dv_quot[TT_W-1])
				time_nx = TT_MAX;
			else
				time_nx = $signed(dv_quot);
		end
		case (dv_meta.status)
			ST_ZERO: time_nx = '0;
			ST_NONE: time_nx = TT_NO_SOL;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= dv_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			time_q <= time_nx;
			status_q <= dv_meta.status;
			axis_q <= dv_meta.axis;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {5'b00000, axis_q, time_q};
	assign m_axis_tuser = status_q;

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none
module testbench import btp_pkg::*;;

	// Testbench for the ballistic time-to-point solver.
	// A driver feeds requests from a queue in random bursts. A monitor stalls the
	// output on its own pattern and compares every result against a behavioral
	// solver kept in this file. Once in the run the output is held off for a long
	// stretch, so the whole pipeline holds and stalls its input.

	typedef struct {
		logic signed [23:0] sx, sy, sz;
		logic signed [19:0] vx, vy, vz;
		logic signed [16:0] g;
		logic signed [23:0] tx, ty, tz;
	} shot_t;

	typedef struct {
		logic signed [24:0] t;
		logic [1:0] status;
		logic [1:0] axis;
	} arrival_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [223:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;

	shot_t pending_shots[$];
	arrival_t expected_arrivals[$];
	int errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_lin = 0, n_quad = 0, n_zero = 0, n_none = 0;
	bit stim_done = 1'b0;
	int holdoff = 0;
	bit hold_done = 1'b0;
	int burst_left = 0;
	int gap_left = 0;

	ballistic_time_to_point_top u_top (.*);

	always #10 clk = ~clk;

	// Rounded, saturated quotient, nearest with ties away from zero.
	function automatic logic signed [24:0] round_div(longint n, longint d);
		longint un, ud, q;
		un = n < 0 ? -n : n;
		ud = d < 0 ? -d : d;
		q = (2 * un + ud) / (2 * ud);
		if ((n < 0) != (d < 0)) begin
			if (q > 64'sd16777216) return TT_MIN;
			return 25'(-q);
		end
		if (q > 64'sd16777215) return TT_MAX;
		return 25'(q);
	endfunction

	// floor(sqrt(disc) * 2^16), bit by bit.
	function automatic longint root_q16(longint disc);
		logic [127:0] val, root, rem, trial;
		val = 128'(disc) << 32;
		root = '0;
		rem = '0;
		for (int k = 63; k >= 0; k--) begin
			rem = (rem << 2) | ((val >> (2 * k)) & 128'd3);
			trial = (root << 2) | 128'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = (root << 1) | 128'd1;
			end else begin
				root = root << 1;
			end
		end
		return longint'(root);
	endfunction

	function automatic arrival_t solve_arrival(shot_t s);
		longint d[3], v[3], m[3], g, disc, sr, vq, lo, hi, num;
		int rank[3];
		int c, tmp;
		arrival_t r;
		d[0] = longint'(s.tx) - longint'(s.sx);
		d[1] = longint'(s.ty) - longint'(s.sy);
		d[2] = longint'(s.tz) - longint'(s.sz);
		v[0] = s.vx;
		v[1] = s.vy;
		v[2] = s.vz;
		g = s.g;
		for (int i = 0; i < 3; i++) begin
			m[i] = d[i] < 0 ? -d[i] : d[i];
			rank[i] = i;
		end
		// Stable ranking by magnitude, larger first, ties to the lower axis.
		for (int i = 1; i < 3; i++)
			for (int j = i; j > 0; j--)
				if (m[rank[j]] > m[rank[j-1]]) begin
					tmp = rank[j];
					rank[j] = rank[j-1];
					rank[j-1] = tmp;
				end
		r.t = TT_NO_SOL;
		r.status = ST_NONE;
		r.axis = AX_NONE;
		if (m[rank[0]] == 0) begin
			r.t = '0;
			r.status = ST_ZERO;
			return r;
		end
		for (int i = 0; i < 3; i++) begin
			c = rank[i];
			if (c == 2 && g != 0) begin
				disc = v[2] * v[2] - 2 * g * d[2];
				if (disc >= 0) begin
					sr = root_q16(disc);
					vq = v[2] * 65536;
					lo = g > 0 ? vq - sr : vq + sr;
					hi = g > 0 ? vq + sr : vq - sr;
					// A root is usable unless numerator and gravity differ in sign.
					if (!((lo < 0 && g > 0) || (lo > 0 && g < 0))) num = lo;
					else if (!((hi < 0 && g > 0) || (hi > 0 && g < 0))) num = hi;
					else continue;
					r.t = round_div(num, g);
					r.status = ST_QUAD;
					r.axis = AX_Z;
					return r;
				end
			end else if (v[c] != 0) begin
				r.t = round_div(d[c] * 65536, v[c]);
				r.status = ST_LIN;
				r.axis = 2'(c);
				return r;
			end
		end
		return r;
	endfunction

	function automatic logic [223:0] pack_shot(shot_t s);
		return {3'b000, s.tz, s.ty, s.tx, s.g, s.vz, s.vy, s.vx, s.sz, s.sy, s.sx};
	endfunction

	function automatic logic signed [23:0] rand_pos(int mode);
		case (mode)
			0: return 24'($urandom);
			1: return 24'($urandom_range(0, 4000)) - 24'sd2000;
			default: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
		endcase
	endfunction

	function automatic logic signed [19:0] rand_vel();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 20'($urandom_range(0, 200)) - 20'sd100;
			2: return $urandom_range(0, 1) ? 20'sh7FFFF : 20'sh80000;
			default: return 20'($urandom);
		endcase
	endfunction

	function automatic shot_t random_shot();
		shot_t s;
		int mode;
		mode = $urandom_range(0, 9) < 6 ? 1 : ($urandom_range(0, 4) == 0 ? 2 : 0);
		s.sx = rand_pos(mode);
		s.sy = rand_pos(mode);
		s.sz = rand_pos(mode);
		s.tx = rand_pos(mode);
		s.ty = rand_pos(mode);
		s.tz = rand_pos(mode);
		// Steer some shots to a mostly vertical difference so the quadratic runs.
		if ($urandom_range(0, 2) == 0) begin
			s.tx = s.sx + 24'($urandom_range(0, 8)) - 24'sd4;
			s.ty = s.sy + 24'($urandom_range(0, 8)) - 24'sd4;
		end
		if ($urandom_range(0, 15) == 0) s.tx = s.sx;
		if ($urandom_range(0, 15) == 0) begin
			s.tx = s.sx;
			s.ty = s.sy;
			s.tz = s.sz;
		end
		s.vx = rand_vel();
		s.vy = rand_vel();
		s.vz = rand_vel();
		case ($urandom_range(0, 5))
			0: s.g = '0;
			1: s.g = $urandom_range(0, 1) ? 17'sh0FFFF : 17'sh10000;
			2: s.g = 17'($urandom_range(0, 400)) - 17'sd200;
			default: s.g = 17'($urandom);
		endcase
		return s;
	endfunction

	function automatic shot_t make_shot(int dx, int dy, int dz, int vx, int vy, int vz, int g);
		shot_t s;
		s.sx = 24'($urandom_range(0, 1000));
		s.sy = -24'sd77;
		s.sz = 24'sd5;
		s.tx = s.sx + 24'(dx);
		s.ty = s.sy + 24'(dy);
		s.tz = s.sz + 24'(dz);
		s.vx = 20'(vx);
		s.vy = 20'(vy);
		s.vz = 20'(vz);
		s.g = 17'(g);
		return s;
	endfunction

	// Directed shots, then the random body of the run.
	initial begin
		shot_t s;
		pending_shots.push_back(make_shot(0, 0, 0, 5, 5, 5, 10));
		pending_shots.push_back(make_shot(160, 10, 0, 32, 0, 0, 0));
		pending_shots.push_back(make_shot(-160, 10, 0, 32, 0, 0, 0));
		pending_shots.push_back(make_shot(100, 100, 100, 0, 0, 0, 0));
		pending_shots.push_back(make_shot(100, 100, 0, 0, 7, 0, 0));
		pending_shots.push_back(make_shot(5, 2, 300, 0, 0, 160, 32));
		pending_shots.push_back(make_shot(5, 2, -300, 0, 0, -160, -32));
		pending_shots.push_back(make_shot(5, 2, 9000, 3, 0, 10, 32));
		pending_shots.push_back(make_shot(5, 2, -300, 0, 0, 0, 32));
		pending_shots.push_back(make_shot(5, 2, 300, 0, 0, -100, -16));
		pending_shots.push_back(make_shot(1, 0, 300, 0, 0, 160, 0));
		pending_shots.push_back(make_shot(1, 0, 1, 0, 0, 2, 0));
		pending_shots.push_back(make_shot(3, 0, 0, 2, 0, 0, 0));
		pending_shots.push_back(make_shot(-3, 0, 0, 2, 0, 0, 0));
		pending_shots.push_back(make_shot(8000000, 0, 0, 1, 0, 0, 0));
		pending_shots.push_back(make_shot(-8000000, 0, 0, 1, 0, 0, 0));
		s.sx = 24'sh800000; s.tx = 24'sh7FFFFF;
		s.sy = 24'sh7FFFFF; s.ty = 24'sh800000;
		s.sz = 24'sh7FFFFF; s.tz = 24'sh800000;
		s.vx = 20'sh80000; s.vy = 20'sh7FFFF; s.vz = 20'sh80000; s.g = 17'sh10000;
		pending_shots.push_back(s);
		s.sz = 24'sh800000; s.tz = 24'sh7FFFFF; s.g = 17'sh0FFFF; s.vz = 20'sh7FFFF;
		s.sx = 24'sd0; s.tx = 24'sd0; s.sy = 24'sd0; s.ty = 24'sd0;
		pending_shots.push_back(s);
		s.sx = 24'hFFFFFF; s.tx = 24'sd0; s.vx = 20'hFFFFF;
		pending_shots.push_back(s);
		for (int i = 0; i < 1700; i++) pending_shots.push_back(random_shot());
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Driver: bursts of requests with random gaps between them.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_arrivals.push_back(solve_arrival(pending_shots.pop_front()));
				n_sent++;
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				// The request on the bus has not been taken yet; keep it.
			end else if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (pending_shots.size() > 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= pack_shot(pending_shots[0]);
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
				end else begin
					burst_left--;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
				stim_done = 1'b1;
			end
		end
	end

	// Monitor: stalls on its own pattern, with one long hold-off early on.
	always @(posedge clk) begin
		arrival_t exp_r;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_arrivals.size() == 0) begin
					$display("%0t: unexpected result tdata=%h tuser=%h", $time,
						m_axis_tdata, m_axis_tuser);
					errors++;
				end else begin
					exp_r = expected_arrivals.pop_front();
					n_checked++;
					case (exp_r.status)
						ST_ZERO: n_zero++;
						ST_LIN: n_lin++;
						ST_QUAD: n_quad++;
						default: n_none++;
					endcase
					if (m_axis_tdata[24:0] !== exp_r.t)
						$display("%0t: flight_time expected %0d got %0d", $time,
							exp_r.t, $signed(m_axis_tdata[24:0]));
					if (m_axis_tdata[26:25] !== exp_r.axis)
						$display("%0t: axis_used expected %0d got %0d", $time,
							exp_r.axis, m_axis_tdata[26:25]);
					if (m_axis_tuser !== exp_r.status)
						$display("%0t: solve_status expected %0d got %0d", $time,
							exp_r.status, m_axis_tuser);
					if (m_axis_tdata[24:0] !== exp_r.t || m_axis_tdata[26:25] !== exp_r.axis
							|| m_axis_tuser !== exp_r.status)
						errors++;
				end
			end
			if (!hold_done && n_sent >= 300) begin
				holdoff <= holdoff + 1;
				m_axis_tready <= 1'b0;
				if (holdoff >= 150) hold_done = 1'b1;
			end else if (($time / 20) % 97 < 30) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= $urandom_range(0, 3) != 0;
			end
		end
	end

	initial begin
		wait (stim_done && expected_arrivals.size() == 0);
		repeat (60) @(posedge clk);
		$display("Checked %0d results: %0d linear, %0d quadratic, %0d zero, %0d unsolved.",
			n_checked, n_lin, n_quad, n_zero, n_none);
		if (errors == 0 && expected_arrivals.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
hw/rtl/btp_pkg.sv
hw/rtl/btp_front.sv
hw/rtl/btp_sqrt.sv
hw/rtl/btp_select.sv
hw/rtl/btp_div.sv
hw/rtl/ballistic_time_to_point_top.sv
test/testbench.sv
